// ===== src/lftc_pkg.sv =====
`default_nettype none
package lftc_pkg;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRAIGHT_LEVEL = 3'd0,
        CFG_INNER_LEVEL    = 3'd1,
        CFG_OUTER_LEVEL    = 3'd2,
        CFG_PWM_PERIOD     = 3'd3,
        CFG_DEBOUNCE_TICKS = 3'd4,
        CFG_COOLDOWN_TICKS = 3'd5,
        CFG_UTURN_TICKS    = 3'd6,
        CFG_LINES_PER_TURN = 3'd7
    } t_cfg_idx;

    localparam logic [7:0]  RST_STRAIGHT_LEVEL = 8'd9;
    localparam logic [7:0]  RST_INNER_LEVEL    = 8'd4;
    localparam logic [7:0]  RST_OUTER_LEVEL    = 8'd5;
    localparam logic [7:0]  RST_PWM_PERIOD     = 8'd20;
    localparam logic [7:0]  RST_DEBOUNCE_TICKS = 8'd20;
    localparam logic [7:0]  RST_COOLDOWN_TICKS = 8'd100;
    localparam logic [15:0] RST_UTURN_TICKS    = 16'd600;
    localparam logic [7:0]  RST_LINES_PER_TURN = 8'd8;

    typedef struct packed {
        logic       left_pwm;
        logic       right_pwm;
        logic [1:0] left_dir;
        logic [1:0] right_dir;
        logic       turning;
        logic [7:0] line_count;
    } t_result;

endpackage
`default_nettype wire

// ===== src/line_follower_tick_controller.sv =====
// output: a tick's result is registered into the result register, or into the skid while the output beat is stalled
// throughput: one tick per cycle while o_ready is high; the whole state update (pwm phases, steering,
// line debounce, u-turn timer) is combinational between the state registers
// a two-entry output stage (result register plus skid); input stalls only once both hold a beat
// reset: synchronous, active low; clears all state, loads default config, empties output
`default_nettype none
module line_follower_tick_controller
    import lftc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_left_sensor,
    input  wire logic                  i_right_sensor,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_left_pwm,
    output logic                       o_right_pwm,
    output logic [1:0]                 o_left_dir,
    output logic [1:0]                 o_right_dir,
    output logic                       o_turning,
    output logic [7:0]                 o_line_count
);

    logic [7:0]  r_straight_level, r_inner_level, r_outer_level, r_pwm_period;
    logic [7:0]  r_debounce_ticks, r_cooldown_ticks, r_lines_per_turn;
    logic [15:0] r_uturn_ticks;

    logic [7:0]  r_left_phase, r_right_phase, r_left_level, r_right_level;
    logic [1:0]  r_left_dir, r_right_dir;
    logic        r_crossing_seen, r_counted_flag, r_uturn_active;
    logic [7:0]  r_debounce_count, r_cooldown_count, r_lines_counted;
    logic [15:0] r_uturn_elapsed;

    logic [7:0]  n_left_phase, n_right_phase, n_left_level, n_right_level;
    logic [1:0]  n_left_dir, n_right_dir;
    logic        n_crossing_seen, n_counted_flag, n_uturn_active;
    logic [7:0]  n_debounce_count, n_cooldown_count, n_lines_counted;
    logic [15:0] n_uturn_elapsed;

    logic [7:0]  left_inc, right_inc, deb_inc;
    logic        left_en, right_en;
    t_result     result;

    t_result     r_out, r_skid;
    logic        r_out_valid, r_skid_valid;
    logic        in_fire, out_fire;

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_straight_level <= RST_STRAIGHT_LEVEL;
            r_inner_level    <= RST_INNER_LEVEL;
            r_outer_level    <= RST_OUTER_LEVEL;
            r_pwm_period     <= RST_PWM_PERIOD;
            r_debounce_ticks <= RST_DEBOUNCE_TICKS;
            r_cooldown_ticks <= RST_COOLDOWN_TICKS;
            r_uturn_ticks    <= RST_UTURN_TICKS;
            r_lines_per_turn <= RST_LINES_PER_TURN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STRAIGHT_LEVEL: r_straight_level <= i_cfg_data[7:0];
                CFG_INNER_LEVEL:    r_inner_level    <= i_cfg_data[7:0];
                CFG_OUTER_LEVEL:    r_outer_level    <= i_cfg_data[7:0];
                CFG_PWM_PERIOD:     r_pwm_period     <= i_cfg_data[7:0];
                CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data[7:0];
                CFG_COOLDOWN_TICKS: r_cooldown_ticks <= i_cfg_data[7:0];
                CFG_UTURN_TICKS:    r_uturn_ticks    <= i_cfg_data[15:0];
                CFG_LINES_PER_TURN: r_lines_per_turn <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pwm phases use the level stored on the previous tick
    always_comb begin
        left_inc     = r_left_phase + 8'd1;
        right_inc    = r_right_phase + 8'd1;
        left_en      = (left_inc <= r_left_level);
        right_en     = (right_inc <= r_right_level);
        n_left_phase  = (left_inc >= r_pwm_period) ? 8'd0 : left_inc;
        n_right_phase = (right_inc >= r_pwm_period) ? 8'd0 : right_inc;
    end

    always_comb begin
        n_left_level     = r_left_level;
        n_right_level    = r_right_level;
        n_left_dir       = r_left_dir;
        n_right_dir      = r_right_dir;
        n_crossing_seen  = r_crossing_seen;
        n_counted_flag   = r_counted_flag;
        n_uturn_active   = r_uturn_active;
        n_debounce_count = r_debounce_count;
        n_cooldown_count = r_cooldown_count;
        n_lines_counted  = r_lines_counted;
        n_uturn_elapsed  = r_uturn_elapsed;
        deb_inc          = (r_debounce_count != 8'hFF) ? r_debounce_count + 8'd1
                                                       : r_debounce_count;

        if (!r_uturn_active) begin
            case ({i_left_sensor, i_right_sensor})
                2'b00: begin
                    n_left_level     = r_straight_level;
                    n_right_level    = r_straight_level;
                    n_left_dir       = DIR_FWD;
                    n_right_dir      = DIR_FWD;
                    n_crossing_seen  = 1'b1;
                    n_counted_flag   = 1'b0;
                    n_debounce_count = 8'd0;
                end
                2'b01: begin
                    n_left_level     = r_outer_level;
                    n_right_level    = r_inner_level;
                    n_left_dir       = DIR_FWD;
                    n_right_dir      = DIR_REV;
                    n_counted_flag   = 1'b0;
                    n_debounce_count = 8'd0;
                end
                2'b10: begin
                    n_left_level     = r_inner_level;
                    n_right_level    = r_outer_level;
                    n_left_dir       = DIR_REV;
                    n_right_dir      = DIR_FWD;
                    n_counted_flag   = 1'b0;
                    n_debounce_count = 8'd0;
                end
                default: begin
                    n_left_level  = r_straight_level;
                    n_right_level = r_straight_level;
                    n_left_dir    = DIR_FWD;
                    n_right_dir   = DIR_FWD;
                    if (r_cooldown_count != 8'd0) begin
                        n_cooldown_count = r_cooldown_count - 8'd1;
                        n_debounce_count = 8'd0;
                    end else if (r_crossing_seen && !r_counted_flag) begin
                        n_debounce_count = deb_inc;
                        if (deb_inc >= r_debounce_ticks) begin
                            n_lines_counted  = r_lines_counted + 8'd1;
                            n_crossing_seen  = 1'b0;
                            n_counted_flag   = 1'b1;
                            n_cooldown_count = r_cooldown_ticks;
                            n_debounce_count = 8'd0;
                        end
                    end else if (!r_crossing_seen) begin
                        n_debounce_count = 8'd0;
                    end
                end
            endcase
            // target reached, or lowered below the count
            if (n_lines_counted >= r_lines_per_turn) begin
                n_uturn_active   = 1'b1;
                n_uturn_elapsed  = 16'd0;
                n_lines_counted  = 8'd0;
                n_crossing_seen  = 1'b0;
                n_counted_flag   = 1'b0;
                n_debounce_count = 8'd0;
                n_cooldown_count = 8'd0;
            end
        end else begin
            n_left_level  = r_straight_level;
            n_right_level = r_straight_level;
            n_left_dir    = DIR_FWD;
            n_right_dir   = DIR_REV;
            if (r_uturn_elapsed != 16'hFFFF) begin
                n_uturn_elapsed = r_uturn_elapsed + 16'd1;
            end
            if (n_uturn_elapsed >= r_uturn_ticks) begin
                n_uturn_active = 1'b0;
            end
        end
    end

    always_comb begin
        result.left_pwm   = left_en;
        result.right_pwm  = right_en;
        result.left_dir   = n_left_dir;
        result.right_dir  = n_right_dir;
        result.turning    = n_uturn_active;
        result.line_count = n_lines_counted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_phase     <= '0;
            r_right_phase    <= '0;
            r_left_level     <= '0;
            r_right_level    <= '0;
            r_left_dir       <= DIR_STOP;
            r_right_dir      <= DIR_STOP;
            r_crossing_seen  <= 1'b0;
            r_counted_flag   <= 1'b0;
            r_uturn_active   <= 1'b0;
            r_debounce_count <= '0;
            r_cooldown_count <= '0;
            r_lines_counted  <= '0;
            r_uturn_elapsed  <= '0;
        end else if (in_fire) begin
            r_left_phase     <= n_left_phase;
            r_right_phase    <= n_right_phase;
            r_left_level     <= n_left_level;
            r_right_level    <= n_right_level;
            r_left_dir       <= n_left_dir;
            r_right_dir      <= n_right_dir;
            r_crossing_seen  <= n_crossing_seen;
            r_counted_flag   <= n_counted_flag;
            r_uturn_active   <= n_uturn_active;
            r_debounce_count <= n_debounce_count;
            r_cooldown_count <= n_cooldown_count;
            r_lines_counted  <= n_lines_counted;
            r_uturn_elapsed  <= n_uturn_elapsed;
        end
    end

    // output register with skid; skid only fills while the output beat is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire) begin
                if (r_out_valid && !i_ready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (r_out_valid && !i_ready) begin
                r_skid <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_left_pwm   = r_out.left_pwm;
    assign o_right_pwm  = r_out.right_pwm;
    assign o_left_dir   = r_out.left_dir;
    assign o_right_dir  = r_out.right_dir;
    assign o_turning    = r_out.turning;
    assign o_line_count = r_out.line_count;

endmodule
`default_nettype wire

// ===== src/lftc_checker.sv =====
`default_nettype none
module lftc_checker
    import lftc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       o_valid,
    input  wire logic       i_ready,
    input  wire logic       o_left_pwm,
    input  wire logic       o_right_pwm,
    input  wire logic [1:0] o_left_dir,
    input  wire logic [1:0] o_right_dir,
    input  wire logic       o_turning,
    input  wire logic [7:0] o_line_count
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_left_pwm) && $stable(o_right_pwm)
            && $stable(o_left_dir) && $stable(o_right_dir) && $stable(o_turning)
            && $stable(o_line_count))
        else $error("result beat changed while stalled");

    // every tick drives both motors
    a_dir_driven: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_left_dir == DIR_FWD || o_left_dir == DIR_REV)
            && (o_right_dir == DIR_FWD || o_right_dir == DIR_REV))
        else $error("motor direction stopped or invalid");

    // the line count is cleared for the whole u-turn
    a_turn_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_turning |-> o_line_count == 8'd0)
        else $error("line count nonzero during u-turn");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule

bind line_follower_tick_controller lftc_checker u_lftc_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import lftc_pkg::*;

    class steering_scoreboard;
        logic [7:0]  straight, inner, outer, period, debounce, cooldown, lines_target;
        logic [15:0] uturn_len;

        logic [7:0]  l_phase, r_phase, l_level, r_level;
        logic [1:0]  l_dir, r_dir;
        bit          crossing, counted, turning;
        logic [7:0]  dbc, cool_left, lines;
        logic [15:0] elapsed;

        t_result due_results[$];
        int errors;
        int beats;

        function new();
            straight = RST_STRAIGHT_LEVEL;
            inner = RST_INNER_LEVEL;
            outer = RST_OUTER_LEVEL;
            period = RST_PWM_PERIOD;
            debounce = RST_DEBOUNCE_TICKS;
            cooldown = RST_COOLDOWN_TICKS;
            uturn_len = RST_UTURN_TICKS;
            lines_target = RST_LINES_PER_TURN;
            l_phase = '0;
            r_phase = '0;
            l_level = '0;
            r_level = '0;
            l_dir = DIR_STOP;
            r_dir = DIR_STOP;
            crossing = 1'b0;
            counted = 1'b0;
            turning = 1'b0;
            dbc = '0;
            cool_left = '0;
            lines = '0;
            elapsed = '0;
            errors = 0;
            beats = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] d);
            case (idx)
                CFG_STRAIGHT_LEVEL: straight = d[7:0];
                CFG_INNER_LEVEL:    inner = d[7:0];
                CFG_OUTER_LEVEL:    outer = d[7:0];
                CFG_PWM_PERIOD:     period = d[7:0];
                CFG_DEBOUNCE_TICKS: debounce = d[7:0];
                CFG_COOLDOWN_TICKS: cooldown = d[7:0];
                CFG_UTURN_TICKS:    uturn_len = d;
                CFG_LINES_PER_TURN: lines_target = d[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // enable uses the level latched on the previous tick
        function void pwm_step(inout logic [7:0] ph, input logic [7:0] lvl, output bit en);
            ph = ph + 8'd1;
            en = (ph <= lvl);
            if (ph >= period)
                ph = '0;
        endfunction

        function void steer(logic [7:0] ll, logic [1:0] ld, logic [7:0] rl, logic [1:0] rd);
            l_level = ll;
            l_dir = ld;
            r_level = rl;
            r_dir = rd;
        endfunction

        function void predict_tick(bit ls, bit rs);
            t_result r;
            bit lp, rp;
            pwm_step(l_phase, l_level, lp);
            pwm_step(r_phase, r_level, rp);
            if (!turning) begin
                if (!ls && !rs) begin
                    steer(straight, DIR_FWD, straight, DIR_FWD);
                    crossing = 1'b1;
                    counted = 1'b0;
                    dbc = '0;
                end else if (!ls) begin
                    steer(outer, DIR_FWD, inner, DIR_REV);
                    counted = 1'b0;
                    dbc = '0;
                end else if (!rs) begin
                    steer(inner, DIR_REV, outer, DIR_FWD);
                    counted = 1'b0;
                    dbc = '0;
                end else begin
                    steer(straight, DIR_FWD, straight, DIR_FWD);
                    if (cool_left != 0) begin
                        cool_left = cool_left - 8'd1;
                        dbc = '0;
                    end else if (crossing && !counted) begin
                        if (dbc != 8'hFF)
                            dbc = dbc + 8'd1;
                        if (dbc >= debounce) begin
                            lines = lines + 8'd1;
                            crossing = 1'b0;
                            counted = 1'b1;
                            cool_left = cooldown;
                            dbc = '0;
                        end
                    end else if (!crossing) begin
                        dbc = '0;
                    end
                end
                // target is checked every tick, so a lowered target fires at once
                if (lines >= lines_target) begin
                    turning = 1'b1;
                    elapsed = '0;
                    lines = '0;
                    crossing = 1'b0;
                    counted = 1'b0;
                    dbc = '0;
                    cool_left = '0;
                end
            end else begin
                steer(straight, DIR_FWD, straight, DIR_REV);
                if (elapsed != 16'hFFFF)
                    elapsed = elapsed + 16'd1;
                if (elapsed >= uturn_len)
                    turning = 1'b0;
            end
            r.left_pwm = lp;
            r.right_pwm = rp;
            r.left_dir = l_dir;
            r.right_dir = r_dir;
            r.turning = turning;
            r.line_count = lines;
            due_results.push_back(r);
        endfunction

        task report(string what);
            if (errors < 100)
                $display("mismatch at result beat %0d: %s", beats, what);
            errors++;
        endtask

        task cmp(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                want = due_results.pop_front();
                cmp("left_pwm", 8'(got.left_pwm), 8'(want.left_pwm));
                cmp("right_pwm", 8'(got.right_pwm), 8'(want.right_pwm));
                cmp("left_dir", 8'(got.left_dir), 8'(want.left_dir));
                cmp("right_dir", 8'(got.right_dir), 8'(want.right_dir));
                cmp("turning", 8'(got.turning), 8'(want.turning));
                cmp("line_count", got.line_count, want.line_count);
            end
            beats++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_left_sensor = 1'b0;
    logic                  i_right_sensor = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_left_pwm;
    logic                  o_right_pwm;
    logic [1:0]            o_left_dir;
    logic [1:0]            o_right_dir;
    logic                  o_turning;
    logic [7:0]            o_line_count;

    steering_scoreboard sb;
    logic [15:0] cfg_next [8];
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    int steered = 0;

    line_follower_tick_controller uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_left_sensor (i_left_sensor),
        .i_right_sensor(i_right_sensor),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_left_pwm    (o_left_pwm),
        .o_right_pwm   (o_right_pwm),
        .o_left_dir    (o_left_dir),
        .o_right_dir   (o_right_dir),
        .o_turning     (o_turning),
        .o_line_count  (o_line_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task send_tick(bit ls, bit rs);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_left_sensor <= ls;
        i_right_sensor <= rs;
        do @(posedge i_clk); while (!o_ready);
        steered++;
        sb.predict_tick(ls, rs);
    endtask

    task drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task load_config();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data <= cfg_next[k];
            @(posedge i_clk);
            sb.write_reg(t_cfg_idx'(k), cfg_next[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task randomise_config();
        cfg_next[CFG_STRAIGHT_LEVEL] = 16'(pick_level());
        cfg_next[CFG_INNER_LEVEL] = 16'(pick_level());
        cfg_next[CFG_OUTER_LEVEL] = 16'(pick_level());
        case ($urandom_range(0, 5))
            0: cfg_next[CFG_PWM_PERIOD] = 16'd1;
            1: cfg_next[CFG_PWM_PERIOD] = 16'd255;
            default: cfg_next[CFG_PWM_PERIOD] = 16'($urandom_range(1, 40));
        endcase
        cfg_next[CFG_DEBOUNCE_TICKS] = 16'($urandom_range(1, 8));
        cfg_next[CFG_COOLDOWN_TICKS] = 16'($urandom_range(0, 10));
        cfg_next[CFG_UTURN_TICKS] = 16'($urandom_range(1, 40));
        cfg_next[CFG_LINES_PER_TURN] = 16'($urandom_range(1, 4));
    endtask

    // a well-formed crossing: dark patch, then a bright run around the debounce length
    task cross_line();
        int n;
        repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(0, 1);
            send_tick(n[0], !n[0]);
        end
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(1, (sb.debounce > 1) ? sb.debounce : 1);
        else
            n = sb.debounce + $urandom_range(0, 3);
        if (n < 1)
            n = 1;
        repeat (n) send_tick(1'b1, 1'b1);
        if ($urandom_range(0, 1) == 0)
            repeat (sb.cooldown + $urandom_range(0, 2)) send_tick(1'b1, 1'b1);
    endtask

    task run_phase(int n);
        int goal;
        int pick;
        int side;
        goal = steered + n;
        while (steered < goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                cross_line();
            end else if (pick < 9) begin
                side = $urandom_range(0, 1);
                repeat ($urandom_range(1, 5)) send_tick(side[0], !side[0]);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // result side: check each beat, then pick the next ready level
    initial begin
        t_result got;
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.left_pwm = o_left_pwm;
                got.right_pwm = o_right_pwm;
                got.left_dir = o_left_dir;
                got.right_dir = o_right_dir;
                got.turning = o_turning;
                got.line_count = o_line_count;
                sb.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall = 60;
            end else if (stall == 0 && idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 6);
            end
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        int phase_no;
        sb = new();
        cfg_next[CFG_STRAIGHT_LEVEL] = 16'(RST_STRAIGHT_LEVEL);
        cfg_next[CFG_INNER_LEVEL] = 16'(RST_INNER_LEVEL);
        cfg_next[CFG_OUTER_LEVEL] = 16'(RST_OUTER_LEVEL);
        cfg_next[CFG_PWM_PERIOD] = 16'(RST_PWM_PERIOD);
        cfg_next[CFG_DEBOUNCE_TICKS] = 16'(RST_DEBOUNCE_TICKS);
        cfg_next[CFG_COOLDOWN_TICKS] = 16'(RST_COOLDOWN_TICKS);
        cfg_next[CFG_UTURN_TICKS] = RST_UTURN_TICKS;
        cfg_next[CFG_LINES_PER_TURN] = 16'(RST_LINES_PER_TURN);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, every sensor pair
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);

        // zero period, zero debounce, zero-length u-turn
        drain();
        cfg_next[CFG_STRAIGHT_LEVEL] = 16'd255;
        cfg_next[CFG_INNER_LEVEL] = 16'd0;
        cfg_next[CFG_OUTER_LEVEL] = 16'd128;
        cfg_next[CFG_PWM_PERIOD] = 16'd0;
        cfg_next[CFG_DEBOUNCE_TICKS] = 16'd0;
        cfg_next[CFG_COOLDOWN_TICKS] = 16'd0;
        cfg_next[CFG_UTURN_TICKS] = 16'd0;
        cfg_next[CFG_LINES_PER_TURN] = 16'd2;
        load_config();
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);

        // zero target starts a u-turn straight away, longest turn length
        drain();
        cfg_next[CFG_PWM_PERIOD] = 16'd255;
        cfg_next[CFG_UTURN_TICKS] = 16'hFFFF;
        cfg_next[CFG_LINES_PER_TURN] = 16'd0;
        load_config();
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);

        // shorten the turn mid-way, then count two lines
        drain();
        cfg_next[CFG_UTURN_TICKS] = 16'd3;
        cfg_next[CFG_LINES_PER_TURN] = 16'd255;
        cfg_next[CFG_DEBOUNCE_TICKS] = 16'd1;
        cfg_next[CFG_PWM_PERIOD] = 16'd1;
        load_config();
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);

        // target lowered below the count
        drain();
        cfg_next[CFG_LINES_PER_TURN] = 16'd1;
        cfg_next[CFG_UTURN_TICKS] = 16'd2;
        load_config();
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        // upper extremes
        drain();
        cfg_next[CFG_STRAIGHT_LEVEL] = 16'd255;
        cfg_next[CFG_INNER_LEVEL] = 16'd0;
        cfg_next[CFG_OUTER_LEVEL] = 16'd255;
        cfg_next[CFG_PWM_PERIOD] = 16'd255;
        cfg_next[CFG_DEBOUNCE_TICKS] = 16'd255;
        cfg_next[CFG_COOLDOWN_TICKS] = 16'd255;
        cfg_next[CFG_UTURN_TICKS] = 16'hFFFF;
        cfg_next[CFG_LINES_PER_TURN] = 16'd255;
        load_config();
        run_phase(120);

        // lower extremes
        drain();
        cfg_next[CFG_STRAIGHT_LEVEL] = 16'd0;
        cfg_next[CFG_INNER_LEVEL] = 16'd255;
        cfg_next[CFG_OUTER_LEVEL] = 16'd0;
        cfg_next[CFG_PWM_PERIOD] = 16'd1;
        cfg_next[CFG_DEBOUNCE_TICKS] = 16'd1;
        cfg_next[CFG_COOLDOWN_TICKS] = 16'd0;
        cfg_next[CFG_UTURN_TICKS] = 16'd1;
        cfg_next[CFG_LINES_PER_TURN] = 16'd1;
        load_config();
        run_phase(120);

        phase_no = 0;
        while (steered < 1850) begin
            drain();
            if (steered > 1500)
                idle_on = 1'b0;
            randomise_config();
            load_config();
            // long result stall so the output stage fills and input backs up
            if (phase_no == 1)
                hold_req = 1'b1;
            run_phase((1850 - steered < 150) ? 1850 - steered : 150);
            phase_no++;
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
